// File: hdl/jbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbp_pkg
// Shared types and constants of the playout jitter buffer.
// ----------------------------------------------------------------------------
package jbp_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned FillW     = 13;
  localparam int unsigned ThrW      = 13;
  localparam int unsigned RefCntW   = 8;
  localparam int unsigned ReqW      = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 13;
  localparam logic [ThrW-1:0] ThrReset = 13'd960;

  typedef enum logic [ReqW-1:0] {
    REQ_ENQ   = 2'd0,
    REQ_PLAY  = 2'd1,
    REQ_FLUSH = 2'd2
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PREBUF = 1'b0,
    CFG_REF_EN = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } ctrl_st_e;

  // Status of one item, handed from control to the output stage.
  typedef struct packed {
    logic             pop;
    logic             ref_frame_end;
    logic             playing;
    logic             overflow;
    logic             underrun;
    logic [FillW-1:0] fill_level;
  } stat_t;

endpackage

// File: hdl/jbp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface jbp_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic signed [15:0]  in_sample;
  logic                period_first;
  logic                period_last;

  modport source (output valid, req_type, in_sample, period_first, period_last,
                  input ready);
  modport sink   (input valid, req_type, in_sample, period_first, period_last,
                  output ready);
endinterface

interface jbp_rsp_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  out_sample;
  logic                ref_frame_end;
  logic                playing;
  logic                overflow;
  logic                underrun;
  logic [12:0]         fill_level;

  modport source (output valid, out_sample, ref_frame_end, playing, overflow,
                  underrun, fill_level, input ready);
  modport sink   (input valid, out_sample, ref_frame_end, playing, overflow,
                  underrun, fill_level, output ready);
endinterface

// File: hdl/jbp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbp_store
// Sample FIFO storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module jbp_store #(
  parameter int unsigned BUFFER_DEPTH = 4096,
  parameter int unsigned AddrW        = $clog2(BUFFER_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [jbp_pkg::SampleW-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [jbp_pkg::SampleW-1:0] rdata_o
);
  import jbp_pkg::*;

  logic [SampleW-1:0] mem_q [BUFFER_DEPTH];
  logic [SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/jbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbp_ctrl
// Playout control: pointers, fill count, start/silence state, reference
// frame counter, config registers, and store access per request beat.
// ----------------------------------------------------------------------------
module jbp_ctrl #(
  parameter int unsigned BUFFER_DEPTH      = 4096,
  parameter int unsigned REF_FRAME_SAMPLES = 160,
  parameter int unsigned AddrW             = $clog2(BUFFER_DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [jbp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [jbp_pkg::CfgDataW-1:0] cfg_data_i,
  jbp_req_if.sink                      in_if,
  input  logic                         out_free_i,
  output logic                         mem_we_o,
  output logic [AddrW-1:0]             mem_waddr_o,
  output logic [jbp_pkg::SampleW-1:0]  mem_wdata_o,
  output logic                         mem_re_o,
  output logic [AddrW-1:0]             mem_raddr_o,
  output logic                         stat_valid_o,
  output jbp_pkg::stat_t               stat_o
);
  import jbp_pkg::*;

  localparam int unsigned CntW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > ThrW) ? CntW : ThrW;
  localparam logic [AddrW-1:0]   LastAddr = AddrW'(BUFFER_DEPTH - 1);
  localparam logic [CntW-1:0]    FullCnt  = CntW'(BUFFER_DEPTH);
  localparam logic [RefCntW-1:0] RefLimit = RefCntW'(REF_FRAME_SAMPLES);

  ctrl_st_e           state_q, state_d;
  logic [AddrW-1:0]   rptr_q, rptr_d;
  logic [AddrW-1:0]   wptr_q, wptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               started_q, started_d;
  logic               silent_q, silent_d;
  logic [RefCntW-1:0] refcnt_q, refcnt_d;
  logic [ThrW-1:0]    thr_q;
  logic               ref_en_q;
  stat_t              stat_q, stat_d;

  logic               accept;
  logic               act, pop, under, ovf, ref_end;
  logic [RefCntW-1:0] refcnt_inc;

  assign in_if.ready = (state_q == ST_IDLE) && out_free_i;
  assign accept      = in_if.valid && in_if.ready;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ThrReset;
      ref_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_PREBUF: thr_q    <= cfg_data_i[ThrW-1:0];
        CFG_REF_EN: ref_en_q <= cfg_data_i[0];
      endcase
    end
  end

  // Item decode and state update
  always_comb begin
    rptr_d     = rptr_q;
    wptr_d     = wptr_q;
    cnt_d      = cnt_q;
    started_d  = started_q;
    silent_d   = silent_q;
    refcnt_d   = refcnt_q;
    act        = 1'b0;
    pop        = 1'b0;
    under      = 1'b0;
    ovf        = 1'b0;
    ref_end    = 1'b0;
    refcnt_inc = refcnt_q + 1'b1;
    mem_we_o   = 1'b0;

    case (req_e'(in_if.req_type))
      REQ_ENQ: begin
        if (cnt_q == FullCnt) begin
          ovf = 1'b1;
        end else begin
          mem_we_o = 1'b1;
          wptr_d   = (wptr_q == LastAddr) ? '0 : wptr_q + 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      REQ_PLAY: begin
        if (in_if.period_first) begin
          silent_d = 1'b0;
          if (!started_q) begin
            if (CmpW'(cnt_q) < CmpW'(thr_q)) begin
              silent_d = 1'b1;
            end else begin
              started_d = 1'b1;
            end
          end
        end
        act = started_d && !silent_d;
        if (act) begin
          if (cnt_q != '0) begin
            pop    = 1'b1;
            rptr_d = (rptr_q == LastAddr) ? '0 : rptr_q + 1'b1;
            cnt_d  = cnt_q - 1'b1;
          end else begin
            under = 1'b1;
          end
          if (ref_en_q) begin
            if (refcnt_inc >= RefLimit) begin
              ref_end  = 1'b1;
              refcnt_d = '0;
            end else begin
              refcnt_d = refcnt_inc;
            end
          end
          if (in_if.period_last && (cnt_d == '0)) begin
            started_d = 1'b0;
          end
        end
        if (in_if.period_last) begin
          silent_d = 1'b0;
        end
      end
      REQ_FLUSH: begin
        rptr_d    = '0;
        wptr_d    = '0;
        cnt_d     = '0;
        started_d = 1'b0;
      end
      default: ;
    endcase

    mem_we_o = mem_we_o && accept;

    stat_d.pop           = pop;
    stat_d.ref_frame_end = ref_end;
    stat_d.playing       = started_d;
    stat_d.overflow      = ovf;
    stat_d.underrun      = under;
    stat_d.fill_level    = FillW'(cnt_d);
  end

  assign mem_waddr_o = wptr_q;
  assign mem_wdata_o = in_if.in_sample;
  assign mem_re_o    = accept && pop;
  assign mem_raddr_o = rptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q    <= '0;
      wptr_q    <= '0;
      cnt_q     <= '0;
      started_q <= 1'b0;
      silent_q  <= 1'b0;
      refcnt_q  <= '0;
    end else if (accept) begin
      rptr_q    <= rptr_d;
      wptr_q    <= wptr_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
      silent_q  <= silent_d;
      refcnt_q  <= refcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stat_q <= stat_d;
    end
  end

  // Sequencer: the read state waits for the registered store read to land
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign stat_valid_o = (state_q == ST_READ);
  assign stat_o       = stat_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("fill count above depth");

  a_start_not_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> !silent_q) else $error("started during a silent period");

  a_refcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refcnt_q < RefLimit) else $error("reference count not wrapped");

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_IDLE)) else $error("read stage stuck");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re_o |-> (cnt_q != '0)) else $error("pop from empty FIFO");
`endif

endmodule

// File: hdl/jbp_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jbp_out
// Result register: merges store read data with item status and holds the
// beat until the sink takes it.
// ----------------------------------------------------------------------------
module jbp_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        stat_valid_i,
  input  jbp_pkg::stat_t              stat_i,
  input  logic [jbp_pkg::SampleW-1:0] rdata_i,
  output logic                        out_free_o,
  jbp_rsp_if.source                   out_if
);
  import jbp_pkg::*;

  logic               valid_q, valid_d;
  logic [SampleW-1:0] sample_q;
  stat_t              stat_q;

  assign out_free_o = !valid_q || out_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (stat_valid_i) begin
      valid_d = 1'b1;
    end else if (out_if.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_valid_i) begin
      sample_q <= stat_i.pop ? rdata_i : '0;
      stat_q   <= stat_i;
    end
  end

  assign out_if.valid         = valid_q;
  assign out_if.out_sample    = sample_q;
  assign out_if.ref_frame_end = stat_q.ref_frame_end;
  assign out_if.playing       = stat_q.playing;
  assign out_if.overflow      = stat_q.overflow;
  assign out_if.underrun      = stat_q.underrun;
  assign out_if.fill_level    = stat_q.fill_level;

endmodule

// File: hdl/jitter_buffer_playout_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jitter_buffer_playout_top
// Audio playout jitter buffer with prebuffering and echo reference marks.
// ----------------------------------------------------------------------------
// Every request beat (enqueue, play, flush) returns exactly one result beat.
// An item runs in order: the accept cycle updates the control state and
// issues the sample store access, and the next cycle loads the registered
// store read data into the output register. The next request is taken once
// that result sits in the output register and the sink can free it, so the
// block takes no request while an item is in its read state. The store
// needs no clearing after reset; only entries already written are read.
module jitter_buffer_playout_top #(
  parameter int unsigned BUFFER_DEPTH      = 4096,
  parameter int unsigned REF_FRAME_SAMPLES = 160
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [jbp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [jbp_pkg::CfgDataW-1:0] cfg_data_i,
  jbp_req_if.sink                      in_if,
  jbp_rsp_if.source                    out_if
);
  import jbp_pkg::*;

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);

  logic               mem_we, mem_re;
  logic [AddrW-1:0]   mem_waddr, mem_raddr;
  logic [SampleW-1:0] mem_wdata, mem_rdata;
  logic               stat_valid, out_free;
  stat_t              stat;

  jbp_ctrl #(
    .BUFFER_DEPTH      (BUFFER_DEPTH),
    .REF_FRAME_SAMPLES (REF_FRAME_SAMPLES),
    .AddrW             (AddrW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_if        (in_if),
    .out_free_i   (out_free),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .stat_valid_o (stat_valid),
    .stat_o       (stat)
  );

  jbp_store #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AddrW        (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  jbp_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stat_valid_i (stat_valid),
    .stat_i       (stat),
    .rdata_i      (mem_rdata),
    .out_free_o   (out_free),
    .out_if       (out_if)
  );

endmodule
